### src/scp_pkg.sv
// Shared types and constants for the size-class buffer pool.
// No dependencies; imported by every module of the block.
package scp_pkg;

	localparam int MaxEntries = 16;
	localparam int ClassCount = 4;
	localparam int HW = $clog2(MaxEntries);
	localparam int CW = $clog2(MaxEntries + 1);

	localparam logic [1:0] KIND_ALLOC = 2'd0;
	localparam logic [1:0] KIND_RELEASE = 2'd1;
	localparam logic [1:0] KIND_TICK = 2'd2;

	localparam logic [2:0] ST_REUSED = 3'd0;
	localparam logic [2:0] ST_CREATED = 3'd1;
	localparam logic [2:0] ST_TOO_BIG = 3'd2;
	localparam logic [2:0] ST_FULL = 3'd3;
	localparam logic [2:0] ST_BAD = 3'd4;

	localparam logic [1:0] E_UNCREATED = 2'd0;
	localparam logic [1:0] E_FREE = 2'd1;
	localparam logic [1:0] E_INUSE = 2'd2;
	localparam logic [1:0] E_PENDING = 2'd3;

	localparam logic [2:0] REG_DELAY = 3'd4;

	// controller -> datapath
	typedef struct packed {
		logic load;      // capture input word
		logic alloc_scan_init;
		logic alloc_step;    // examine one free-list slot
		logic alloc_shift;   // compact free list by one
		logic alloc_finish;  // create or report full
		logic release_do;
		logic tick_init;
		logic tick_step;
		logic tick_finish;
		logic other_do;      // unknown kind
	} scp_cmd_t;

	// datapath -> controller
	typedef struct packed {
		logic [1:0] kind;
		logic too_big;
		logic scan_done;     // scan exhausted
		logic hit;           // match at current scan slot
		logic shift_done;
		logic tick_done;
	} scp_stat_t;

endpackage

### src/scp_datapath.sv
// Datapath: entry tables, free and pending lists, counters, result register.
// Depends on scp_pkg.
module scp_datapath (
	input  logic clk,
	input  logic arst_n,
	input  scp_pkg::scp_cmd_t cmd,
	output scp_pkg::scp_stat_t stat,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic [1:0] kind,
	input  logic [31:0] required_size,
	input  logic [4:0] usage,
	input  logic [3:0] handle,
	output logic [2:0] res_status,
	output logic [3:0] res_handle,
	output logic [1:0] res_class,
	output logic [4:0] res_freed
);
	import scp_pkg::*;

	logic [31:0] class_size_q [ClassCount];
	logic [3:0] delay_q;

	logic [1:0] kind_q;
	logic [4:0] usage_q;
	logic [3:0] handle_q;
	logic [1:0] cls_q;
	logic too_big_q;

	logic [1:0] e_class_q [MaxEntries];
	logic [4:0] e_usage_q [MaxEntries];
	logic [1:0] e_stat_q [MaxEntries];
	logic [3:0] e_cnt_q [MaxEntries];
	logic [HW-1:0] free_q [MaxEntries];
	logic [HW-1:0] pend_q [MaxEntries];
	logic [CW-1:0] created_q, free_cnt_q, pend_cnt_q;

	logic [CW-1:0] idx_q, kept_q, freed_q;
	logic [HW-1:0] cur_e;
	logic [HW-1:0] pend_e;

	// first class that fits
	logic [1:0] cls_d;
	logic fit_d;
	always_comb begin
		cls_d = '0;
		fit_d = 1'b0;
		for (int c = ClassCount - 1; c >= 0; c--) begin
			if (class_size_q[c] != 32'd0 && class_size_q[c] >= required_size) begin
				cls_d = 2'(c);
				fit_d = 1'b1;
			end
		end
	end

	assign cur_e = free_q[idx_q[HW-1:0]];
	assign pend_e = pend_q[idx_q[HW-1:0]];

	assign stat.kind = kind_q;
	assign stat.too_big = too_big_q;
	assign stat.scan_done = (idx_q >= free_cnt_q);
	assign stat.hit = (e_class_q[cur_e] == cls_q) && (e_usage_q[cur_e] == usage_q);
	assign stat.shift_done = (idx_q + CW'(1) >= free_cnt_q);
	assign stat.tick_done = (idx_q >= pend_cnt_q);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int c = 0; c < ClassCount; c++) class_size_q[c] <= '0;
			delay_q <= 4'd2;
		end else if (cfg_we) begin
			if (cfg_index == REG_DELAY) delay_q <= cfg_data[3:0];
			else if (cfg_index < 3'(ClassCount)) class_size_q[cfg_index[1:0]] <= cfg_data;
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.load) begin
			kind_q <= kind;
			usage_q <= usage;
			handle_q <= handle;
			cls_q <= cls_d;
			too_big_q <= !fit_d;
		end
	end

	// tables without reset
	always_ff @(posedge clk) begin
		if (cmd.alloc_finish && created_q < CW'(MaxEntries)) begin
			e_class_q[created_q[HW-1:0]] <= cls_q;
			e_usage_q[created_q[HW-1:0]] <= usage_q;
			e_cnt_q[created_q[HW-1:0]] <= '0;
		end
		if (cmd.release_do && e_stat_q[handle_q] == E_INUSE && pend_cnt_q < CW'(MaxEntries)) begin
			e_cnt_q[handle_q] <= delay_q;
			pend_q[pend_cnt_q[HW-1:0]] <= handle_q;
		end
		if (cmd.alloc_shift && !stat.shift_done)
			free_q[idx_q[HW-1:0]] <= free_q[HW'(idx_q + CW'(1))];
		if (cmd.tick_step && !stat.tick_done) begin
			if (e_cnt_q[pend_e] == 4'd0) begin
				if (free_cnt_q < CW'(MaxEntries)) free_q[free_cnt_q[HW-1:0]] <= pend_e;
			end else begin
				e_cnt_q[pend_e] <= e_cnt_q[pend_e] - 4'd1;
				pend_q[kept_q[HW-1:0]] <= pend_e;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < MaxEntries; i++) e_stat_q[i] <= E_UNCREATED;
			created_q <= '0;
			free_cnt_q <= '0;
			pend_cnt_q <= '0;
			idx_q <= '0;
			kept_q <= '0;
			freed_q <= '0;
			res_status <= '0;
			res_handle <= '0;
			res_class <= '0;
			res_freed <= '0;
		end else begin
			if (cmd.alloc_scan_init || cmd.tick_init) begin
				idx_q <= '0;
				kept_q <= '0;
				freed_q <= '0;
			end
			if (cmd.alloc_step) begin
				if (too_big_q) begin
					res_status <= ST_TOO_BIG;
					res_handle <= '0;
					res_class <= '0;
					res_freed <= '0;
				end else if (!stat.scan_done && stat.hit) begin
					e_stat_q[cur_e] <= E_INUSE;
					res_status <= ST_REUSED;
					res_handle <= cur_e;
					res_class <= cls_q;
					res_freed <= '0;
				end else if (!stat.scan_done) begin
					idx_q <= idx_q + CW'(1);
				end
			end
			if (cmd.alloc_shift) begin
				if (stat.shift_done) free_cnt_q <= free_cnt_q - CW'(1);
				else idx_q <= idx_q + CW'(1);
			end
			if (cmd.alloc_finish) begin
				res_class <= cls_q;
				res_freed <= '0;
				if (created_q >= CW'(MaxEntries)) begin
					res_status <= ST_FULL;
					res_handle <= '0;
				end else begin
					e_stat_q[created_q[HW-1:0]] <= E_INUSE;
					created_q <= created_q + CW'(1);
					res_status <= ST_CREATED;
					res_handle <= created_q[HW-1:0];
				end
			end
			if (cmd.release_do) begin
				res_handle <= '0;
				res_class <= '0;
				res_freed <= '0;
				if (e_stat_q[handle_q] == E_INUSE && pend_cnt_q < CW'(MaxEntries)) begin
					e_stat_q[handle_q] <= E_PENDING;
					pend_cnt_q <= pend_cnt_q + CW'(1);
					res_status <= ST_REUSED;
				end else begin
					res_status <= ST_BAD;
				end
			end
			if (cmd.tick_step && !stat.tick_done) begin
				idx_q <= idx_q + CW'(1);
				if (e_cnt_q[pend_e] == 4'd0) begin
					if (free_cnt_q < CW'(MaxEntries)) free_cnt_q <= free_cnt_q + CW'(1);
					e_stat_q[pend_e] <= E_FREE;
					freed_q <= freed_q + CW'(1);
				end else begin
					kept_q <= kept_q + CW'(1);
				end
			end
			if (cmd.tick_finish) begin
				pend_cnt_q <= kept_q;
				res_status <= ST_REUSED;
				res_handle <= '0;
				res_class <= '0;
				res_freed <= 5'(freed_q);
			end
			if (cmd.other_do) begin
				res_status <= '0;
				res_handle <= '0;
				res_class <= '0;
				res_freed <= '0;
			end
		end
	end

endmodule

### src/scp_ctrl.sv
// Controller state machine: sequences allocate scan, compaction, tick walk.
// Depends on scp_pkg.
module scp_ctrl (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_stall,
	output logic out_valid,
	input  logic out_stall,
	output scp_pkg::scp_cmd_t cmd,
	input  scp_pkg::scp_stat_t stat
);
	import scp_pkg::*;

	typedef enum logic [6:0] {
		S_IDLE  = 7'b0000001,
		S_DISP  = 7'b0000010,
		S_SCAN  = 7'b0000100,
		S_SHIFT = 7'b0001000,
		S_MAKE  = 7'b0010000,
		S_TICK  = 7'b0100000,
		S_OUT   = 7'b1000000
	} state_t;

	state_t state_q, state_d;
	logic ov_q;

	// accept only in idle, when no result waits or the waiting one leaves now
	assign in_stall = (state_q != S_IDLE) || (ov_q && out_stall);
	assign out_valid = ov_q;

	always_comb begin
		cmd = '0;
		state_d = state_q;
		case (state_q)
			S_IDLE: begin
				if (in_valid && !in_stall) begin
					cmd.load = 1'b1;
					state_d = S_DISP;
				end
			end
			S_DISP: begin
				case (stat.kind)
					KIND_ALLOC: begin
						cmd.alloc_scan_init = 1'b1;
						state_d = S_SCAN;
					end
					KIND_RELEASE: begin
						cmd.release_do = 1'b1;
						state_d = S_OUT;
					end
					KIND_TICK: begin
						cmd.tick_init = 1'b1;
						state_d = S_TICK;
					end
					default: begin
						cmd.other_do = 1'b1;
						state_d = S_OUT;
					end
				endcase
			end
			S_SCAN: begin
				cmd.alloc_step = 1'b1;
				if (stat.too_big) state_d = S_OUT;
				else if (stat.scan_done) state_d = S_MAKE;
				else if (stat.hit) state_d = S_SHIFT;
			end
			S_SHIFT: begin
				cmd.alloc_shift = 1'b1;
				if (stat.shift_done) state_d = S_OUT;
			end
			S_MAKE: begin
				cmd.alloc_finish = 1'b1;
				state_d = S_OUT;
			end
			S_TICK: begin
				if (stat.tick_done) begin
					cmd.tick_finish = 1'b1;
					state_d = S_OUT;
				end else begin
					cmd.tick_step = 1'b1;
				end
			end
			S_OUT: state_d = S_IDLE;
			default: state_d = S_IDLE;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
			ov_q <= 1'b0;
		end else begin
			state_q <= state_d;
			if (state_q == S_OUT) ov_q <= 1'b1;
			else if (!out_stall) ov_q <= 1'b0;
		end
	end

endmodule

### src/size_class_pool_deferred_release.sv
// Top level of the size-class buffer pool with deferred release.
// Depends on scp_pkg, scp_ctrl and scp_datapath.
//
// Input channel (in_valid/in_stall) carries one word: kind, required_size,
// usage, handle. kind 0 allocates, 1 releases handle, 2 is a frame tick.
// Output channel (out_valid/out_stall) returns exactly one word per input:
// status, granted_handle, size_class, freed_count.
// A release or an unknown kind goes from dispatch straight to the output
// state; an allocate that no class fits leaves at its first scan step, any
// other allocate scans the free list, then compacts it on a hit, or else
// creates an entry or finds the pool full; a tick walks the pending list.
// Throughput is one word at a time: the free-list scan and its compaction,
// and the pending-list walk, each advance one list slot per cycle.
// The result sits in an output register; while the receiver stalls it is
// held, and a new word is accepted only once it is taken (or in that cycle).
// Reset (arst_n low) empties both lists, marks all entries uncreated, clears
// class sizes and sets release_delay to 2. Configuration writes (cfg_we,
// cfg_index, cfg_data) take effect at once; the user must have them issued
// only while idle, since the block itself does not enforce it.
module size_class_pool_deferred_release (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	output logic in_stall,
	input  logic [1:0] kind,
	input  logic [31:0] required_size,
	input  logic [4:0] usage,
	input  logic [3:0] handle,
	output logic out_valid,
	input  logic out_stall,
	output logic [2:0] status,
	output logic [3:0] granted_handle,
	output logic [1:0] size_class,
	output logic [4:0] freed_count
);
	import scp_pkg::*;

	scp_cmd_t cmd;
	scp_stat_t stat;

	scp_ctrl u_ctrl (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall),
		.out_valid(out_valid), .out_stall(out_stall),
		.cmd(cmd), .stat(stat)
	);

	scp_datapath u_dp (
		.clk(clk), .arst_n(arst_n),
		.cmd(cmd), .stat(stat),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.kind(kind), .required_size(required_size), .usage(usage), .handle(handle),
		.res_status(status), .res_handle(granted_handle),
		.res_class(size_class), .res_freed(freed_count)
	);

endmodule

### test/scp_checker.sv
// Checker for the size-class buffer pool: watches both channels and the register port,
// predicts each result and compares it field by field. Depends on scp_pkg.
`timescale 1ns / 1ps
module scp_checker (
	input  logic clk,
	input  logic arst_n,
	input  logic cfg_we,
	input  logic [2:0] cfg_index,
	input  logic [31:0] cfg_data,
	input  logic in_valid,
	input  logic in_stall,
	input  logic [1:0] kind,
	input  logic [31:0] required_size,
	input  logic [4:0] usage,
	input  logic [3:0] handle,
	input  logic out_valid,
	input  logic out_stall,
	input  logic [2:0] status,
	input  logic [3:0] granted_handle,
	input  logic [1:0] size_class,
	input  logic [4:0] freed_count,
	output int errors,
	output int outstanding
);
	import scp_pkg::*;

	typedef struct packed {
		logic [2:0] status;
		logic [3:0] handle;
		logic [1:0] cls;
		logic [4:0] freed;
	} pool_reply_t;

	logic [31:0] class_bytes[ClassCount];
	logic [3:0] delay_load;
	logic [1:0] ent_class[MaxEntries];
	logic [4:0] ent_usage[MaxEntries];
	logic [1:0] ent_state[MaxEntries];
	logic [3:0] ent_timer[MaxEntries];
	int created;
	int free_order[$];
	int release_order[$];
	pool_reply_t replies_due[$];

	assign outstanding = replies_due.size();

	function automatic pool_reply_t pool_step(logic [1:0] k, logic [31:0] req,
			logic [4:0] use_code, logic [3:0] h);
		pool_reply_t r;
		logic [1:0] cls;
		int hit;
		int e;
		int kept[$];
		r = '0;
		cls = '0;
		hit = -1;
		if (k == KIND_ALLOC) begin
			// round up to the first live class that holds the request
			for (int c = ClassCount - 1; c >= 0; c--)
				if (class_bytes[c] != 0 && class_bytes[c] >= req) begin
					cls = c[1:0];
					hit = 0;
				end
			if (hit < 0) begin
				r.status = ST_TOO_BIG;
				return r;
			end
			hit = -1;
			foreach (free_order[i])
				if (hit < 0 && ent_class[free_order[i]] == cls &&
						ent_usage[free_order[i]] == use_code)
					hit = i;
			r.cls = cls;
			if (hit >= 0) begin
				e = free_order[hit];
				free_order.delete(hit);
				ent_state[e] = E_INUSE;
				r.status = ST_REUSED;
				r.handle = e[3:0];
			end else if (created >= MaxEntries) begin
				r.status = ST_FULL;
			end else begin
				ent_class[created] = cls;
				ent_usage[created] = use_code;
				ent_state[created] = E_INUSE;
				ent_timer[created] = '0;
				r.status = ST_CREATED;
				r.handle = created[3:0];
				created++;
			end
		end else if (k == KIND_RELEASE) begin
			if (ent_state[h] != E_INUSE || release_order.size() >= MaxEntries) begin
				r.status = ST_BAD;
			end else begin
				ent_state[h] = E_PENDING;
				ent_timer[h] = delay_load;
				release_order = {release_order, int'(h)};
			end
		end else if (k == KIND_TICK) begin
			foreach (release_order[i]) begin
				e = release_order[i];
				if (ent_timer[e] == 0) begin
					free_order = {free_order, e};
					ent_state[e] = E_FREE;
					r.freed++;
				end else begin
					ent_timer[e]--;
					kept = {kept, e};
				end
			end
			release_order = kept;
		end
		return r;
	endfunction

	always @(posedge clk or negedge arst_n) begin
		pool_reply_t want;
		if (!arst_n) begin
			foreach (class_bytes[c]) class_bytes[c] = '0;
			delay_load = 4'd2;
			foreach (ent_state[e]) ent_state[e] = E_UNCREATED;
			created = 0;
			free_order.delete();
			release_order.delete();
			replies_due.delete();
			errors = 0;
		end else begin
			if (cfg_we) begin
				if (cfg_index < ClassCount) class_bytes[cfg_index] = cfg_data;
				else if (cfg_index == REG_DELAY) delay_load = cfg_data[3:0];
			end
			if (out_valid && !out_stall) begin
				if (replies_due.size() == 0) begin
					$error("unexpected word: status %0d", status);
					errors++;
				end else begin
					want = replies_due.pop_front();
					if (status !== want.status) begin
						$error("status: expected %0d, got %0d", want.status, status);
						errors++;
					end
					if (granted_handle !== want.handle) begin
						$error("granted_handle: expected %0d, got %0d",
							want.handle, granted_handle);
						errors++;
					end
					if (size_class !== want.cls) begin
						$error("size_class: expected %0d, got %0d", want.cls, size_class);
						errors++;
					end
					if (freed_count !== want.freed) begin
						$error("freed_count: expected %0d, got %0d",
							want.freed, freed_count);
						errors++;
					end
				end
			end
			if (in_valid && !in_stall)
				replies_due = {replies_due,
					pool_step(kind, required_size, usage, handle)};
		end
	end

endmodule

### test/tb_size_class_pool_deferred_release.sv
// Testbench top for the size-class buffer pool: drives directed and random words
// through several register settings and gives the verdict. Depends on scp_pkg, scp_checker.
`timescale 1ns / 1ps
module tb_size_class_pool_deferred_release;
	import scp_pkg::*;

	localparam logic [2:0] REG_CLASS_BASE = 3'd0;
	localparam int CycleLimit = 400000;
	localparam int SettleCycles = 2 * MaxEntries + 12;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [31:0] cfg_data = '0;
	logic in_valid = 1'b0;
	logic in_stall;
	logic [1:0] kind = KIND_TICK;
	logic [31:0] required_size = '0;
	logic [4:0] usage = '0;
	logic [3:0] handle = '0;
	logic out_valid;
	logic out_stall = 1'b0;
	logic [2:0] status;
	logic [3:0] granted_handle;
	logic [1:0] size_class;
	logic [4:0] freed_count;
	int errors;
	int outstanding;

	// local copy of the class table, used to aim sizes at class boundaries
	logic [31:0] class_now[ClassCount];
	bit calm;       // phase with no gaps and no stalls on either side
	bit took;       // a result word left the block at the last edge
	int stall_left;
	int words_sent;
	int settings_seen;
	int cycles;

	size_class_pool_deferred_release i_dut (.*);

	scp_checker i_checker (.*);

	always begin
		#4 clk = 1'b1;
		#4 clk = 1'b0;
	end

	always @(posedge clk) begin
		cycles <= cycles + 1;
		took <= out_valid && !out_stall;
		if (cycles > CycleLimit) begin
			$display("status: fail");
			$finish;
		end
	end

	// Receiver: after each word taken, draw a fresh stall length.
	always @(negedge clk) begin
		if (took) stall_left = calm ? 0 : $urandom_range(0, 18);
		if (stall_left > 0) begin
			out_stall <= 1'b1;
			stall_left--;
		end else begin
			out_stall <= 1'b0;
		end
	end

	// Present one word after a random gap; hold it until the block takes it.
	task automatic send_word(logic [1:0] k, logic [31:0] sz, logic [4:0] u, logic [3:0] h);
		int gap;
		gap = calm ? 0 : $urandom_range(0, 18);
		@(negedge clk);
		if (gap != 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(negedge clk);
		end
		in_valid <= 1'b1;
		kind <= k;
		required_size <= sz;
		usage <= u;
		handle <= h;
		do @(posedge clk); while (in_stall);
		words_sent++;
	endtask

	// Drain the block, then write one register.
	task automatic write_reg(logic [2:0] idx, logic [31:0] value);
		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		cfg_we <= 1'b1;
		cfg_index <= idx;
		cfg_data <= value;
		if (idx < ClassCount) class_now[idx] = value;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic load_setting(logic [31:0] c0, logic [31:0] c1, logic [31:0] c2,
			logic [31:0] c3, logic [3:0] delay);
		write_reg(REG_CLASS_BASE, c0);
		write_reg(REG_CLASS_BASE + 3'd1, c1);
		write_reg(REG_CLASS_BASE + 3'd2, c2);
		write_reg(REG_CLASS_BASE + 3'd3, c3);
		write_reg(REG_DELAY, {28'd0, delay});
		settings_seen++;
	endtask

	// Aim near a class edge half of the time so both fit and overflow occur.
	function automatic logic [31:0] pick_size();
		logic [31:0] edge_bytes;
		edge_bytes = class_now[$urandom_range(0, ClassCount - 1)];
		case ($urandom_range(0, 5))
			0: return edge_bytes;
			1: return edge_bytes - 1;
			2: return edge_bytes + 1;
			3: return $urandom;
			4: return '0;
			default: return '1;
		endcase
	endfunction

	task automatic random_phase(int count);
		int pick;
		for (int n = 0; n < count; n++) begin
			pick = $urandom_range(0, 99);
			if (pick < 45)
				send_word(KIND_ALLOC, pick_size(),
					($urandom_range(0, 9) == 0) ? 5'($urandom_range(0, 31))
						: 5'($urandom_range(0, 3)),
					4'($urandom));
			else if (pick < 75)
				send_word(KIND_RELEASE, $urandom, 5'($urandom), 4'($urandom_range(0, 15)));
			else if (pick < 97)
				send_word(KIND_TICK, $urandom, 5'($urandom), 4'($urandom));
			else
				send_word(2'd3, $urandom, 5'($urandom), 4'($urandom));
		end
	endtask

	initial begin
		foreach (class_now[c]) class_now[c] = '0;
		calm = 1'b1;
		stall_left = 0;
		words_sent = 0;
		settings_seen = 1;
		cycles = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		// All classes unused after reset: every allocate is too big.
		send_word(KIND_ALLOC, '0, 5'd31, '0);
		send_word(2'd3, '1, 5'd31, 4'd15);
		send_word(KIND_RELEASE, '0, '0, 4'd15);    // uncreated entry
		send_word(KIND_TICK, '0, '0, '0);

		load_setting(32'd16, 32'd256, 32'd65536, 32'hFFFF_FFFF, 4'd0);
		// Fill the pool with every pairing of class and usage 0 to 3, then overflow it.
		for (int i = 0; i < MaxEntries; i++)
			send_word(KIND_ALLOC, class_now[i % ClassCount], 5'(i / ClassCount), '0);
		send_word(KIND_ALLOC, 32'hFFFF_FFFF, 5'd31, '0);   // pool full
		send_word(KIND_RELEASE, '0, '0, 4'd0);
		send_word(KIND_RELEASE, '0, '0, 4'd0);            // already pending
		send_word(KIND_TICK, '0, '0, '0);
		send_word(KIND_RELEASE, '0, '0, 4'd0);            // already free
		send_word(KIND_ALLOC, 32'd1, 5'd0, '0);           // reuse of entry 0

		calm = 1'b0;
		random_phase(170);
		load_setting(32'd16, 32'd256, 32'd65536, 32'hFFFF_FFFF, 4'd15);
		calm = 1'b1;
		random_phase(60);
		calm = 1'b0;
		random_phase(110);
		load_setting(32'd1, 32'd2, 32'd3, 32'd0, 4'd3);
		random_phase(170);
		load_setting(32'd0, 32'd50, 32'd0, 32'd1000, 4'd1);
		random_phase(170);

		@(negedge clk);
		in_valid <= 1'b0;
		while (outstanding != 0) @(negedge clk);
		repeat (SettleCycles) @(negedge clk);
		$display("covered %0d words across %0d register settings, with and without idling",
			words_sent, settings_seen);
		if (errors == 0) begin
			$display("status: pass");
		end else begin
			$display("status: fail");
		end
		$finish;
	end

endmodule

### size_class_pool_deferred_release.f
src/scp_pkg.sv
src/scp_datapath.sv
src/scp_ctrl.sv
src/size_class_pool_deferred_release.sv
test/scp_checker.sv
test/tb_size_class_pool_deferred_release.sv
